@@ src/slrl_pkg.sv @@
// Shared types and constants for the server registry with least-loaded selection.
// Used by the controller, the datapath, the top level and the port checker.
package slrl_pkg;

    localparam logic [2:0] CMD_REGISTER   = 3'd0;
    localparam logic [2:0] CMD_UNREGISTER = 3'd1;
    localparam logic [2:0] CMD_HEARTBEAT  = 3'd2;
    localparam logic [2:0] CMD_PICK       = 3'd3;
    localparam logic [2:0] CMD_LOOKUP     = 3'd4;
    localparam logic [2:0] CMD_EXPIRE     = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_NONE      = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;

    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] conn_id;
        logic [31:0] server_addr;
        logic [15:0] server_port;
        logic [7:0]  room_capacity;
        logic [7:0]  rooms_in_use;
        logic [31:0] now_ticks;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [15:0] out_conn_id;
        logic [31:0] out_addr;
        logic [15:0] out_port;
        logic [7:0]  out_capacity;
        logic [7:0]  out_in_use;
        logic [4:0]  active_count;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] conn;
        logic [7:0]  capacity;
        logic [7:0]  in_use;
        logic [31:0] seen;
    } entry_t;

    typedef struct packed {
        logic load;
        logic run;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic known_cmd;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

@@ src/server_registry_least_loaded.sv @@
// Server registry with least-loaded selection and heartbeat timeout, top level.
// Instantiates slrl_ctrl and slrl_dpath; port types come from slrl_pkg.
//
// Every known command walks the whole table of SLOTS entries through the single
// read port of the entry memory, one entry per cycle unless an expire sweep
// pauses, and one command is handled at a time. The reserved command codes skip
// the walk and go straight to the final result. An expire sweep pauses whenever
// it has an expired entry to report while its result register is still held by
// the consumer. Results wait in an output register, so the next command is taken
// while the previous final result is pending.
module server_registry_least_loaded
#(
    parameter int SLOTS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  slrl_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output slrl_pkg::rsp_t rsp,
    input  logic           timeout_we,
    input  logic [31:0]    timeout_wdata
);

    slrl_pkg::dp_cmd_t  dcmd;
    slrl_pkg::dp_stat_t stat;

    slrl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .dcmd      (dcmd)
    );

    slrl_dpath
    #(
        .SLOTS (SLOTS)
    )
    u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .timeout_we    (timeout_we),
        .timeout_wdata (timeout_wdata),
        .rsp           (rsp),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .dcmd          (dcmd),
        .stat          (stat)
    );

endmodule

@@ src/slrl_ctrl.sv @@
// Command sequencer for the server registry: accept, table scan, final result.
// Depends on slrl_pkg for the command and status structs.
module slrl_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  slrl_pkg::dp_stat_t stat,
    output slrl_pkg::dp_cmd_t  dcmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        dcmd.load   = 1'b0;
        dcmd.run    = 1'b0;
        dcmd.finish = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    dcmd.load  = 1'b1;
                    state_next = stat.known_cmd ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                dcmd.run = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    dcmd.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/slrl_dpath.sv @@
// Datapath of the server registry: entry memory, valid bits, scan pipeline,
// search registers, timeout register and the result register. Uses slrl_pkg.
module slrl_dpath
#(
    parameter int SLOTS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  slrl_pkg::req_t     req,
    input  logic               timeout_we,
    input  logic [31:0]        timeout_wdata,
    output slrl_pkg::rsp_t     rsp,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  slrl_pkg::dp_cmd_t  dcmd,
    output slrl_pkg::dp_stat_t stat
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    slrl_pkg::entry_t mem [0:SLOTS-1];
    slrl_pkg::entry_t rd_data_reg;

    slrl_pkg::req_t   req_reg, req_next;
    slrl_pkg::entry_t sel_entry_reg, sel_entry_next;
    slrl_pkg::rsp_t   rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic [CW-1:0]    addr_reg, addr_next;
    logic             ev_valid_reg, ev_valid_next;
    logic [IW-1:0]    ev_idx_reg, ev_idx_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    sel_idx_reg, sel_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    logic [7:0]       best_reg, best_next;
    logic [31:0]      timeout_reg;

    logic             ev_live;
    logic [31:0]      age;
    logic             exp_hit;
    logic             out_free;
    logic             advance;
    logic             issue;
    logic [8:0]       free_rooms;
    logic [IW-1:0]    tgt_idx;
    logic             mem_we;
    logic [IW-1:0]    mem_wa;
    slrl_pkg::entry_t mem_wd;
    logic             rsp_load;

    assign ev_live    = valid_reg[ev_idx_reg];
    assign age        = req_reg.now_ticks - rd_data_reg.seen;
    assign exp_hit    = ev_valid_reg && ev_live && (req_reg.command == slrl_pkg::CMD_EXPIRE)
                        && (age > timeout_reg);
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign advance    = dcmd.run && !(exp_hit && !out_free);
    assign issue      = advance && (addr_reg != CW'(SLOTS));
    assign free_rooms = {1'b0, rd_data_reg.capacity} - {1'b0, rd_data_reg.in_use};
    assign tgt_idx    = found_reg ? sel_idx_reg : free_idx_reg;

    assign stat.known_cmd = (req.command <= slrl_pkg::CMD_EXPIRE);
    assign stat.scan_done = (addr_reg == CW'(SLOTS)) && !ev_valid_reg;
    assign stat.out_free  = out_free;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        req_next        = req_reg;
        sel_entry_next  = sel_entry_reg;
        rsp_next        = rsp_reg;
        rsp_load        = 1'b0;
        addr_next       = addr_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        sel_idx_next    = sel_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_next       = best_reg;
        mem_we          = 1'b0;
        mem_wa          = tgt_idx;
        mem_wd          = sel_entry_reg;

        if (dcmd.load)
        begin
            req_next        = req;
            addr_next       = '0;
            ev_valid_next   = 1'b0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
            best_next       = '0;
        end

        if (advance)
        begin
            if (ev_valid_reg)
            begin
                unique case (req_reg.command)
                    slrl_pkg::CMD_REGISTER:
                    begin
                        if (ev_live && !found_reg && rd_data_reg.addr == req_reg.server_addr
                            && rd_data_reg.port == req_reg.server_port)
                        begin
                            found_next   = 1'b1;
                            sel_idx_next = ev_idx_reg;
                        end
                        if (!ev_live && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = ev_idx_reg;
                        end
                    end
                    slrl_pkg::CMD_UNREGISTER, slrl_pkg::CMD_HEARTBEAT,
                    slrl_pkg::CMD_LOOKUP:
                    begin
                        if (ev_live && !found_reg && rd_data_reg.conn == req_reg.conn_id)
                        begin
                            found_next     = 1'b1;
                            sel_idx_next   = ev_idx_reg;
                            sel_entry_next = rd_data_reg;
                        end
                    end
                    slrl_pkg::CMD_PICK:
                    begin
                        if (ev_live && !free_rooms[8] && free_rooms[7:0] > best_reg)
                        begin
                            found_next     = 1'b1;
                            sel_idx_next   = ev_idx_reg;
                            sel_entry_next = rd_data_reg;
                            best_next      = free_rooms[7:0];
                        end
                    end
                    slrl_pkg::CMD_EXPIRE:
                    begin
                        if (exp_hit)
                        begin
                            valid_next[ev_idx_reg] = 1'b0;
                            count_next             = count_reg - CW'(1);
                            rsp_load               = 1'b1;
                            rsp_next.status        = slrl_pkg::ST_EXPIRED;
                            rsp_next.slot          = 4'(ev_idx_reg);
                            rsp_next.out_conn_id   = rd_data_reg.conn;
                            rsp_next.out_addr      = rd_data_reg.addr;
                            rsp_next.out_port      = rd_data_reg.port;
                            rsp_next.out_capacity  = rd_data_reg.capacity;
                            rsp_next.out_in_use    = rd_data_reg.in_use;
                            rsp_next.last          = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (issue)
            begin
                addr_next     = addr_reg + CW'(1);
                ev_valid_next = 1'b1;
                ev_idx_next   = addr_reg[IW-1:0];
            end
            else
            begin
                ev_valid_next = 1'b0;
            end
        end

        if (dcmd.finish)
        begin
            rsp_load              = 1'b1;
            rsp_next.status       = slrl_pkg::ST_OK;
            rsp_next.slot         = '0;
            rsp_next.out_conn_id  = '0;
            rsp_next.out_addr     = '0;
            rsp_next.out_port     = '0;
            rsp_next.out_capacity = '0;
            rsp_next.out_in_use   = '0;
            rsp_next.last         = 1'b1;
            unique case (req_reg.command)
                slrl_pkg::CMD_REGISTER:
                begin
                    if (found_reg || free_found_reg)
                    begin
                        mem_we          = 1'b1;
                        mem_wd.addr     = req_reg.server_addr;
                        mem_wd.port     = req_reg.server_port;
                        mem_wd.conn     = req_reg.conn_id;
                        mem_wd.capacity = req_reg.room_capacity;
                        mem_wd.in_use   = req_reg.rooms_in_use;
                        mem_wd.seen     = req_reg.now_ticks;
                        if (!found_reg)
                        begin
                            valid_next[tgt_idx] = 1'b1;
                            count_next          = count_reg + CW'(1);
                        end
                        rsp_next.slot         = 4'(tgt_idx);
                        rsp_next.out_conn_id  = req_reg.conn_id;
                        rsp_next.out_addr     = req_reg.server_addr;
                        rsp_next.out_port     = req_reg.server_port;
                        rsp_next.out_capacity = req_reg.room_capacity;
                        rsp_next.out_in_use   = req_reg.rooms_in_use;
                    end
                    else
                    begin
                        rsp_next.status = slrl_pkg::ST_FULL;
                    end
                end
                slrl_pkg::CMD_UNREGISTER, slrl_pkg::CMD_HEARTBEAT,
                slrl_pkg::CMD_PICK, slrl_pkg::CMD_LOOKUP:
                begin
                    if (found_reg)
                    begin
                        rsp_next.slot         = 4'(sel_idx_reg);
                        rsp_next.out_conn_id  = sel_entry_reg.conn;
                        rsp_next.out_addr     = sel_entry_reg.addr;
                        rsp_next.out_port     = sel_entry_reg.port;
                        rsp_next.out_capacity = sel_entry_reg.capacity;
                        rsp_next.out_in_use   = sel_entry_reg.in_use;
                        if (req_reg.command == slrl_pkg::CMD_UNREGISTER)
                        begin
                            valid_next[sel_idx_reg] = 1'b0;
                            count_next              = count_reg - CW'(1);
                        end
                        if (req_reg.command == slrl_pkg::CMD_HEARTBEAT)
                        begin
                            mem_we              = 1'b1;
                            mem_wd.in_use       = req_reg.rooms_in_use;
                            mem_wd.seen         = req_reg.now_ticks;
                            rsp_next.out_in_use = req_reg.rooms_in_use;
                        end
                    end
                    else if (req_reg.command == slrl_pkg::CMD_PICK)
                    begin
                        rsp_next.status = slrl_pkg::ST_NONE;
                    end
                    else
                    begin
                        rsp_next.status = slrl_pkg::ST_NOT_FOUND;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (rsp_load)
        begin
            rsp_next.active_count = 5'(count_next);
            rsp_valid_next        = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (issue)
        begin
            rd_data_reg <= mem[addr_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        sel_entry_reg <= sel_entry_next;
        rsp_reg       <= rsp_next;
        ev_idx_reg    <= ev_idx_next;
        sel_idx_reg   <= sel_idx_next;
        free_idx_reg  <= free_idx_next;
        best_reg      <= best_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            addr_reg       <= CW'(SLOTS);
            ev_valid_reg   <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            timeout_reg    <= slrl_pkg::TIMEOUT_RESET;
        end
        else
        begin
            rsp_valid_reg  <= rsp_valid_next;
            addr_reg       <= addr_next;
            ev_valid_reg   <= ev_valid_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            if (timeout_we)
            begin
                timeout_reg <= timeout_wdata;
            end
        end
    end

endmodule

@@ src/slrl_checker.sv @@
// Port-level checker for the server registry, bound to the top level.
// Depends on slrl_pkg for the result struct and status codes.
module slrl_checker
#(
    parameter int SLOTS = 16
)
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input slrl_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("Result changed while stalled.");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("A second command was taken before the first finished.");

    a_expired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == slrl_pkg::ST_EXPIRED |-> !rsp.last)
        else $error("An expired-entry result closed the command.");

    a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == slrl_pkg::ST_FULL || rsp.status == slrl_pkg::ST_NOT_FOUND
        || rsp.status == slrl_pkg::ST_NONE) |-> rsp.slot == '0 && rsp.out_addr == '0
        && rsp.out_conn_id == '0)
        else $error("A result without an entry carries entry fields.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (SLOTS > 31) || (32'(rsp.active_count) <= 32'(SLOTS)))
        else $error("Active count exceeds the table size.");

endmodule

bind server_registry_least_loaded slrl_checker #(.SLOTS(SLOTS)) u_slrl_checker (.*);

@@ test/server_registry_least_loaded_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for server_registry_least_loaded: directed and random registry traffic.
// Keeps its own model of the server table to predict every result; needs only slrl_pkg and the RTL.
module server_registry_least_loaded_tb;

    localparam int SLOTS = 16;
    localparam int KEYS = 20;
    localparam int CONNS = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [2:0] CMD_RESERVED_6 = 3'd6;
    localparam logic [2:0] CMD_RESERVED_7 = 3'd7;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    slrl_pkg::req_t req = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    slrl_pkg::rsp_t rsp;
    logic           timeout_we = 1'b0;
    logic [31:0]    timeout_wdata = '0;

    bit          send_gaps = 1'b1;
    bit          recv_gaps = 1'b1;
    int          hold_asks = 0;
    int          holds_done = 0;
    int          hold_left = 0;
    int          failures = 0;
    int          cycle_count = 0;

    logic [31:0] sim_ticks = '0;
    logic [31:0] key_addr [KEYS];
    logic [15:0] key_port [KEYS];
    logic [15:0] conn_ids [CONNS];

    bit               tbl_valid [SLOTS];
    slrl_pkg::entry_t tbl_entry [SLOTS];
    logic [31:0]      timeout_setting = slrl_pkg::TIMEOUT_RESET;
    slrl_pkg::rsp_t   pending_results [$];
    slrl_pkg::rsp_t   want;

    server_registry_least_loaded #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .timeout_we(timeout_we),
        .timeout_wdata(timeout_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // A long hold-off is counted here so that the sender keeps offering items meanwhile.
    always @(negedge clk)
    begin
        if (holds_done != hold_asks)
        begin
            holds_done = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= recv_gaps && ($urandom_range(99) < 29);
        end
    end

    function automatic slrl_pkg::rsp_t registry_result(logic [2:0] status, int slot, bit last);
        slrl_pkg::rsp_t o;
        int             active;
        o = '0;
        active = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tbl_valid[i])
            begin
                active++;
            end
        end
        o.status = status;
        if (slot >= 0)
        begin
            o.slot = slot[3:0];
            o.out_conn_id = tbl_entry[slot].conn;
            o.out_addr = tbl_entry[slot].addr;
            o.out_port = tbl_entry[slot].port;
            o.out_capacity = tbl_entry[slot].capacity;
            o.out_in_use = tbl_entry[slot].in_use;
        end
        o.active_count = active[4:0];
        o.last = last;
        return o;
    endfunction

    function automatic int find_conn(logic [15:0] conn);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tbl_valid[i] && tbl_entry[i].conn == conn)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic predict_registry(input slrl_pkg::req_t r);
        int          hit;
        int          best;
        int          room;
        logic [31:0] age;
        hit = -1;
        case (r.command)
            slrl_pkg::CMD_REGISTER:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (hit < 0 && tbl_valid[i] && tbl_entry[i].addr == r.server_addr
                        && tbl_entry[i].port == r.server_port)
                    begin
                        hit = i;
                    end
                end
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (hit < 0 && !tbl_valid[i])
                    begin
                        hit = i;
                    end
                end
                if (hit < 0)
                begin
                    pending_results.push_back(registry_result(slrl_pkg::ST_FULL, -1, 1'b1));
                end
                else
                begin
                    tbl_valid[hit] = 1'b1;
                    tbl_entry[hit].addr = r.server_addr;
                    tbl_entry[hit].port = r.server_port;
                    tbl_entry[hit].conn = r.conn_id;
                    tbl_entry[hit].capacity = r.room_capacity;
                    tbl_entry[hit].in_use = r.rooms_in_use;
                    tbl_entry[hit].seen = r.now_ticks;
                    pending_results.push_back(registry_result(slrl_pkg::ST_OK, hit, 1'b1));
                end
            end
            slrl_pkg::CMD_UNREGISTER, slrl_pkg::CMD_HEARTBEAT, slrl_pkg::CMD_LOOKUP:
            begin
                hit = find_conn(r.conn_id);
                if (hit < 0)
                begin
                    pending_results.push_back(
                        registry_result(slrl_pkg::ST_NOT_FOUND, -1, 1'b1));
                end
                else
                begin
                    if (r.command == slrl_pkg::CMD_UNREGISTER)
                    begin
                        tbl_valid[hit] = 1'b0;
                    end
                    else if (r.command == slrl_pkg::CMD_HEARTBEAT)
                    begin
                        tbl_entry[hit].in_use = r.rooms_in_use;
                        tbl_entry[hit].seen = r.now_ticks;
                    end
                    pending_results.push_back(registry_result(slrl_pkg::ST_OK, hit, 1'b1));
                end
            end
            slrl_pkg::CMD_PICK:
            begin
                best = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    room = int'(tbl_entry[i].capacity) - int'(tbl_entry[i].in_use);
                    if (tbl_valid[i] && room > best)
                    begin
                        best = room;
                        hit = i;
                    end
                end
                pending_results.push_back(registry_result(
                    hit < 0 ? slrl_pkg::ST_NONE : slrl_pkg::ST_OK, hit, 1'b1));
            end
            slrl_pkg::CMD_EXPIRE:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    age = r.now_ticks - tbl_entry[i].seen;
                    if (tbl_valid[i] && age > timeout_setting)
                    begin
                        tbl_valid[i] = 1'b0;
                        pending_results.push_back(
                            registry_result(slrl_pkg::ST_EXPIRED, i, 1'b0));
                    end
                end
                pending_results.push_back(registry_result(slrl_pkg::ST_OK, -1, 1'b1));
            end
            default:
            begin
                pending_results.push_back(registry_result(slrl_pkg::ST_OK, -1, 1'b1));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, got_val);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $error("Result transfer with nothing expected: status %0d slot %0d",
                       rsp.status, rsp.slot);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(rsp.status));
                check_field("slot", 32'(want.slot), 32'(rsp.slot));
                check_field("out_conn_id", 32'(want.out_conn_id), 32'(rsp.out_conn_id));
                check_field("out_addr", want.out_addr, rsp.out_addr);
                check_field("out_port", 32'(want.out_port), 32'(rsp.out_port));
                check_field("out_capacity", 32'(want.out_capacity), 32'(rsp.out_capacity));
                check_field("out_in_use", 32'(want.out_in_use), 32'(rsp.out_in_use));
                check_field("active_count", 32'(want.active_count), 32'(rsp.active_count));
                check_field("last", 32'(want.last), 32'(rsp.last));
            end
        end
    end

    task automatic send_request(input slrl_pkg::req_t r);
        @(negedge clk);
        while (send_gaps && $urandom_range(99) < 29)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        predict_registry(r);
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_timeout(input logic [31:0] ticks);
        drain_results();
        @(negedge clk);
        timeout_we <= 1'b1;
        timeout_wdata <= ticks;
        @(negedge clk);
        timeout_we <= 1'b0;
        timeout_setting = ticks;
    endtask

    function automatic slrl_pkg::req_t make_req(logic [2:0] cmd, logic [15:0] conn,
                                                logic [31:0] addr, logic [15:0] port,
                                                logic [7:0] cap, logic [7:0] busy,
                                                logic [31:0] ticks);
        slrl_pkg::req_t r;
        r.command = cmd;
        r.conn_id = conn;
        r.server_addr = addr;
        r.server_port = port;
        r.room_capacity = cap;
        r.rooms_in_use = busy;
        r.now_ticks = ticks;
        return r;
    endfunction

    task automatic next_request(output slrl_pkg::req_t r);
        int roll;
        int k;
        roll = $urandom_range(99);
        k = $urandom_range(KEYS - 1);
        sim_ticks = sim_ticks + $urandom_range(6000);
        if ($urandom_range(99) < 3)
        begin
            sim_ticks = $urandom;
        end
        r.conn_id = conn_ids[$urandom_range(CONNS - 1)];
        r.server_addr = key_addr[k];
        r.server_port = key_port[k];
        r.room_capacity = 8'($urandom_range(255));
        r.rooms_in_use = ($urandom_range(9) < 8) ? 8'($urandom_range(r.room_capacity))
                                                 : 8'($urandom_range(255));
        r.now_ticks = sim_ticks;
        if (roll < 30)
            r.command = slrl_pkg::CMD_REGISTER;
        else if (roll < 40)
            r.command = slrl_pkg::CMD_UNREGISTER;
        else if (roll < 58)
            r.command = slrl_pkg::CMD_HEARTBEAT;
        else if (roll < 72)
            r.command = slrl_pkg::CMD_PICK;
        else if (roll < 84)
            r.command = slrl_pkg::CMD_LOOKUP;
        else if (roll < 96)
            r.command = slrl_pkg::CMD_EXPIRE;
        else
            r.command = ($urandom_range(1) == 1) ? CMD_RESERVED_7 : CMD_RESERVED_6;
        if ($urandom_range(99) < 10)
        begin
            r.command = 3'($urandom_range(7));
            r.conn_id = 16'($urandom);
            r.server_addr = $urandom;
            r.server_port = 16'($urandom);
            r.room_capacity = 8'($urandom);
            r.rooms_in_use = 8'($urandom);
            r.now_ticks = $urandom;
        end
    endtask

    task automatic test_random_traffic(input int count);
        slrl_pkg::req_t r;
        repeat (count)
        begin
            next_request(r);
            send_request(r);
        end
    endtask

    task automatic test_empty_table();
        send_request(make_req(slrl_pkg::CMD_PICK, 16'h0000, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'h0));
        send_request(make_req(slrl_pkg::CMD_LOOKUP, 16'h1234, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'h0));
        send_request(make_req(slrl_pkg::CMD_UNREGISTER, 16'h1234, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'h0));
        send_request(make_req(slrl_pkg::CMD_HEARTBEAT, 16'h1234, 32'h0, 16'h0, 8'h00, 8'h10,
                              32'h5));
        send_request(make_req(CMD_RESERVED_6, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF,
                              8'hFF, 32'hFFFF_FFFF));
        send_request(make_req(CMD_RESERVED_7, 16'h0000, 32'h0, 16'h0, 8'h00, 8'h00, 32'h0));
    endtask

    task automatic test_register_and_pick();
        send_request(make_req(slrl_pkg::CMD_REGISTER, 16'h0000, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'h0));
        send_request(make_req(slrl_pkg::CMD_REGISTER, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                              8'hFF, 8'h00, 32'hFFFF_FFFF));
        // Capacity below rooms in use, with a connection id shared with the entry above.
        send_request(make_req(slrl_pkg::CMD_REGISTER, 16'hFFFF, 32'h0, 16'hFFFF, 8'h0A,
                              8'hC8, 32'd100));
        // Same key as the first entry, so it is updated and now ties with the second on pick.
        send_request(make_req(slrl_pkg::CMD_REGISTER, 16'h0005, 32'h0, 16'h0, 8'hFF, 8'h00,
                              32'd200));
        send_request(make_req(slrl_pkg::CMD_PICK, 16'h0000, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'h0));
        send_request(make_req(slrl_pkg::CMD_LOOKUP, 16'hFFFF, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'h0));
        send_request(make_req(slrl_pkg::CMD_HEARTBEAT, 16'hFFFF, 32'h0, 16'h0, 8'h00, 8'hFF,
                              32'd300));
        send_request(make_req(slrl_pkg::CMD_UNREGISTER, 16'h0005, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'h0));
        send_request(make_req(slrl_pkg::CMD_PICK, 16'h0000, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'h0));
        send_request(make_req(slrl_pkg::CMD_UNREGISTER, 16'hFFFF, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'h0));
        send_request(make_req(slrl_pkg::CMD_LOOKUP, 16'hFFFF, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'h0));
    endtask

    task automatic test_expire_boundaries();
        set_timeout(32'd1000);
        send_request(make_req(slrl_pkg::CMD_REGISTER, 16'h0007, 32'h0A00_0003, 16'd7000,
                              8'd20, 8'd5, 32'hFFFF_FF00));
        send_request(make_req(slrl_pkg::CMD_EXPIRE, 16'h0000, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'h0000_0200));
        send_request(make_req(slrl_pkg::CMD_REGISTER, 16'h0009, 32'h0A00_0004, 16'd7001,
                              8'd8, 8'd1, 32'd2000));
        // An age equal to the timeout is kept; one tick more removes the entry.
        send_request(make_req(slrl_pkg::CMD_EXPIRE, 16'h0000, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'd3000));
        send_request(make_req(slrl_pkg::CMD_EXPIRE, 16'h0000, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'd3001));
        send_request(make_req(slrl_pkg::CMD_EXPIRE, 16'h0000, 32'h0, 16'h0, 8'h00, 8'h00,
                              32'd9000));
    endtask

    task automatic test_table_full();
        set_timeout(32'hFFFF_FFFF);
        sim_ticks = 32'hFFFF_0000;
        repeat (SLOTS + 2)
        begin
            sim_ticks = sim_ticks + $urandom_range(4000);
            send_request(make_req(slrl_pkg::CMD_REGISTER, 16'($urandom), $urandom,
                                  16'($urandom), 8'($urandom), 8'($urandom), sim_ticks));
        end
        test_random_traffic(15);
    endtask

    task automatic test_zero_timeout();
        set_timeout(32'd0);
        test_random_traffic(20);
    endtask

    task automatic test_back_to_back();
        set_timeout($urandom_range(40000, 500));
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        test_random_traffic(30);
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    task automatic test_receiver_hold();
        send_gaps = 1'b0;
        hold_asks++;
        test_random_traffic(14);
        send_gaps = 1'b1;
    endtask

    initial
    begin
        for (int i = 0; i < KEYS; i++)
        begin
            key_addr[i] = $urandom;
            key_port[i] = 16'($urandom);
        end
        for (int i = 0; i < CONNS; i++)
        begin
            conn_ids[i] = 16'($urandom);
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_entry[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_register_and_pick();
        test_expire_boundaries();
        set_timeout(slrl_pkg::TIMEOUT_RESET);
        test_random_traffic(15);
        test_table_full();
        test_zero_timeout();
        test_back_to_back();
        test_receiver_hold();
        set_timeout($urandom_range(60000, 2000));
        test_random_traffic(25);

        drain_results();
        repeat (2 * (SLOTS + 3)) @(posedge clk);
        if (failures == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/slrl_pkg.sv
src/slrl_ctrl.sv
src/slrl_dpath.sv
src/server_registry_least_loaded.sv
src/slrl_checker.sv
test/server_registry_least_loaded_tb.sv
